/* hw/rtl/voxel_cdf_index_sampler_macros.svh */
// assertion macros shared by the sampler rtl
// expects clk and rst in the scope of each use
`ifndef VOXEL_CDF_INDEX_SAMPLER_MACROS_SVH
`define VOXEL_CDF_INDEX_SAMPLER_MACROS_SVH

// same-cycle implication
`define VCIS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VCIS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/vcis_pkg.sv */
// types, constants and the row search function of the voxel cdf sampler
// no dependencies
package vcis_pkg;

  localparam int TAB_DEPTH  = 16;
  localparam int IDX_W      = $clog2(TAB_DEPTH);
  localparam int CNT_W      = $clog2(TAB_DEPTH + 1);
  localparam int PROB_BITS  = 32;
  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam int IN_W   = 144;
  localparam int OUT_W  = 16;
  localparam int USER_W = 2;
  localparam int CIDX_W = 2;

  localparam logic [CIDX_W-1:0] REG_Z_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] REG_Y_COUNT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_X_COUNT = 2'd2;

  typedef logic [PROB_BITS-1:0] prob_t;
  typedef prob_t [TAB_DEPTH-1:0] row_t;

  typedef enum logic [1:0] {
    ACT_WR_Z   = 2'd0,
    ACT_WR_Y   = 2'd1,
    ACT_WR_X   = 2'd2,
    ACT_SAMPLE = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZOVER = 2'd1,
    ST_YOVER = 2'd2,
    ST_XOVER = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ZSCAN,
    S_YSCAN,
    S_XSCAN,
    S_EMIT
  } back_state_t;

  // data0 holds the entry value for writes and draw_z for samples
  typedef struct packed {
    act_t             kind;
    logic [IDX_W-1:0] pos_z;
    logic [IDX_W-1:0] pos_y;
    logic [IDX_W-1:0] pos_x;
    prob_t            data0;
    prob_t            data1;
    prob_t            data2;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [1:0]       pad;
    status_t          status;
    logic [IDX_W-1:0] column_index;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] slice_index;
  } res_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } hit_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(TAB_DEPTH);
    return (c > lim) ? lim : c;
  endfunction

  // first lane below n whose entry is at least the draw
  function automatic hit_t first_hit(input row_t row, input prob_t draw,
                                     input logic [CNT_W-1:0] n);
    hit_t r;
    r = '0;
    for (int l = TAB_DEPTH - 1; l >= 0; l--) begin
      if ((CNT_W'(l) < n) && (row[l] >= draw)) begin
        r.hit = 1'b1;
        r.idx = IDX_W'(l);
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/vcis_front.sv */
// input side: accepts stream transactions and turns them into queue commands
// depends on vcis_pkg
module vcis_front (
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [vcis_pkg::IN_W-1:0] s_tdata,
  input  logic [vcis_pkg::USER_W-1:0] s_tuser,
  input  vcis_pkg::fifo_stat_t      q_stat,
  output logic                      q_push,
  output vcis_pkg::cmd_t            q_cmd
);
  import vcis_pkg::*;

  act_t  kind;
  prob_t entry_value;
  prob_t draw_z;

  assign kind        = act_t'(s_tuser);
  assign entry_value = s_tdata[43:12];
  assign draw_z      = s_tdata[75:44];

  assign s_tready = !q_stat.full;
  assign q_push   = s_tvalid && !q_stat.full;

  always_comb begin
    q_cmd       = '0;
    q_cmd.kind  = kind;
    q_cmd.pos_z = s_tdata[3:0];
    q_cmd.pos_y = s_tdata[7:4];
    q_cmd.pos_x = s_tdata[11:8];
    case (kind)
      ACT_SAMPLE: begin
        q_cmd.data0 = draw_z;
        q_cmd.data1 = s_tdata[107:76];
        q_cmd.data2 = s_tdata[139:108];
      end
      default: begin
        q_cmd.data0 = entry_value;
      end
    endcase
  end

endmodule

/* hw/rtl/vcis_fifo.sv */
// short command queue between the front and back of the sampler
// depends on vcis_pkg and the assertion macro header
`include "voxel_cdf_index_sampler_macros.svh"
module vcis_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  vcis_pkg::cmd_t       push_cmd,
  input  logic                 pop,
  output vcis_pkg::cmd_t       pop_cmd,
  output vcis_pkg::fifo_stat_t stat
);
  import vcis_pkg::*;

  cmd_t              slots [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr;
  logic [FPTR_W-1:0] rd_ptr;
  logic [FCNT_W-1:0] count;

  function automatic logic [FPTR_W-1:0] bump(input logic [FPTR_W-1:0] p);
    return (p == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (count == FCNT_W'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign pop_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `VCIS_ASSERT_IMPL(a_no_overflow, push, !stat.full, "push into full queue")
  `VCIS_ASSERT_IMPL(a_no_underflow, pop, !stat.empty, "pop from empty queue")
  `VCIS_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "queue count lost a push")

endmodule

/* hw/rtl/vcis_back.sv */
// back end: table storage, three level row search and the result register
// depends on vcis_pkg and the assertion macro header
`include "voxel_cdf_index_sampler_macros.svh"
module vcis_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [vcis_pkg::CIDX_W-1:0] cfg_index,
  input  logic [vcis_pkg::CNT_W-1:0] cfg_wr_data,
  input  vcis_pkg::cmd_t             cmd,
  input  vcis_pkg::fifo_stat_t       q_stat,
  output logic                       pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [vcis_pkg::OUT_W-1:0] m_tdata
);
  import vcis_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [CNT_W-1:0] z_count;
  logic [CNT_W-1:0] y_count;
  logic [CNT_W-1:0] x_count;

  prob_t z_tab [TAB_DEPTH];
  row_t  z_row;
  row_t  y_mem [TAB_DEPTH];
  row_t  x_mem [TAB_DEPTH * TAB_DEPTH];
  row_t  y_rdata;
  row_t  x_rdata;

  prob_t            dz;
  prob_t            dy;
  prob_t            dx;
  logic [IDX_W-1:0] idx_i;
  logic [IDX_W-1:0] idx_j;
  logic [IDX_W-1:0] idx_k;
  status_t          res_status;

  hit_t hz;
  hit_t hy;
  hit_t hx;

  logic z_we;
  logic y_we;
  logic x_we;
  logic start;
  logic load;

  logic out_valid;
  res_t out_data;
  res_t res;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      z_count <= CNT_W'(TAB_DEPTH);
      y_count <= CNT_W'(TAB_DEPTH);
      x_count <= CNT_W'(TAB_DEPTH);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_Z_COUNT: z_count <= cfg_wr_data;
        REG_Y_COUNT: y_count <= cfg_wr_data;
        REG_X_COUNT: x_count <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int l = 0; l < TAB_DEPTH; l++) begin
      z_row[l] = z_tab[l];
    end
  end

  assign hz = first_hit(z_row, dz, clamp_count(z_count));
  assign hy = first_hit(y_rdata, dy, clamp_count(y_count));
  assign hx = first_hit(x_rdata, dx, clamp_count(x_count));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!q_stat.empty && cmd.kind == ACT_SAMPLE) begin
          state_next = S_ZSCAN;
        end
      end
      S_ZSCAN: state_next = hz.hit ? S_YSCAN : S_EMIT;
      S_YSCAN: state_next = hy.hit ? S_XSCAN : S_EMIT;
      S_XSCAN: state_next = S_EMIT;
      S_EMIT: begin
        if (!out_valid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop   = 1'b0;
    z_we  = 1'b0;
    y_we  = 1'b0;
    x_we  = 1'b0;
    start = 1'b0;
    load  = 1'b0;
    case (state)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          case (cmd.kind)
            ACT_WR_Z:   z_we  = 1'b1;
            ACT_WR_Y:   y_we  = 1'b1;
            ACT_WR_X:   x_we  = 1'b1;
            ACT_SAMPLE: start = 1'b1;
            default: ;
          endcase
        end
      end
      S_EMIT: load = !out_valid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // tables
  always_ff @(posedge clk) begin
    if (z_we) begin
      z_tab[cmd.pos_z] <= cmd.data0;
    end
  end

  always_ff @(posedge clk) begin
    if (y_we) begin
      y_mem[cmd.pos_z][cmd.pos_y] <= cmd.data0;
    end
    y_rdata <= y_mem[hz.idx];
  end

  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[{cmd.pos_z, cmd.pos_y}][cmd.pos_x] <= cmd.data0;
    end
    x_rdata <= x_mem[{idx_i, hy.idx}];
  end

  // search datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          dz         <= cmd.data0;
          dy         <= cmd.data1;
          dx         <= cmd.data2;
          res_status <= ST_OK;
        end
      end
      S_ZSCAN: begin
        idx_i <= hz.idx;
        if (!hz.hit) begin
          res_status <= ST_ZOVER;
        end
      end
      S_YSCAN: begin
        idx_j <= hy.idx;
        if (!hy.hit) begin
          res_status <= ST_YOVER;
        end
      end
      S_XSCAN: begin
        idx_k <= hx.idx;
        if (!hx.hit) begin
          res_status <= ST_XOVER;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res        = '0;
    res.status = res_status;
    if (res_status == ST_OK) begin
      res.slice_index  = idx_i;
      res.row_index    = idx_j;
      res.column_index = idx_k;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  `VCIS_ASSERT_NEXT(a_load_shows, load, out_valid, "loaded result not shown")
  `VCIS_ASSERT_IMPL(a_reject_zero, out_valid && out_data.status != ST_OK, out_data.slice_index == '0 && out_data.row_index == '0 && out_data.column_index == '0, "rejected result carries an index")
  `VCIS_ASSERT_NEXT(a_sample_starts, start, state == S_ZSCAN, "sample did not enter the slice search")

endmodule

/* hw/rtl/voxel_cdf_index_sampler.sv */
// three level inverse cdf voxel index sampler, top level
// a sample goes through pop, slice compare, row compare, column compare and emit in order;
// a slice overrun skips the row and column compares, a row overrun the column compare;
// emit holds while the output is stalled; commands, table writes included, pop only in idle
// reset clears control state and sets every count to 16; table contents stay undefined
// depends on vcis_pkg, vcis_front, vcis_fifo and vcis_back
module voxel_cdf_index_sampler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [vcis_pkg::CIDX_W-1:0] cfg_index,
  input  logic [vcis_pkg::CNT_W-1:0]  cfg_wr_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // pos_z, pos_y, pos_x, entry_value, draw_z, draw_y, draw_x, zero fill
  input  logic [vcis_pkg::IN_W-1:0]   s_tdata,
  // action
  input  logic [vcis_pkg::USER_W-1:0] s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // slice_index, row_index, column_index, status, zero fill
  output logic [vcis_pkg::OUT_W-1:0]  m_tdata
);
  import vcis_pkg::*;

  fifo_stat_t q_stat;
  logic       q_push;
  logic       q_pop;
  cmd_t       q_in;
  cmd_t       q_out;

  vcis_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  vcis_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .pop_cmd  (q_out),
    .stat     (q_stat)
  );

  vcis_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (q_out),
    .q_stat      (q_stat),
    .pop         (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule
